// ===== sv/tspmt_pkg.sv =====
// Shared types and constants of the PMT section generator.
package tspmt_pkg;

  localparam int BYTE_W    = 8;
  localparam int VER_W     = 5;
  localparam int DLEN_W    = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 10;
  localparam int CRC_W     = 32;
  localparam int IDX_W     = 5;

  localparam int HDR_LEN = 18;
  localparam int CRC_LEN = 4;

  localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 32'h04C1_1DB7;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_DESC  = 1'b1
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ES_TYPE     = 3'd0,
    REG_VERSION     = 3'd1,
    REG_CUR_NEXT    = 3'd2,
    REG_DESC_LEN    = 3'd3,
    REG_PID_LOW     = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] es_type;
    logic [VER_W-1:0]  version;
    logic              cur_next;
    logic [DLEN_W-1:0] desc_len;
    logic [BYTE_W-1:0] pid_low;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] out_byte;
    logic              section_end;
    logic              run_last;
    logic              stray_error;
  } res_t;

endpackage

// ===== sv/tspmt_in_if.sv =====
// Input word channel: action and descriptor byte.
interface tspmt_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [tspmt_pkg::BYTE_W-1:0]  descriptor_byte;

  modport source (output valid, action, descriptor_byte, input ready);
  modport sink   (input valid, action, descriptor_byte, output ready);
endinterface

// ===== sv/tspmt_out_if.sv =====
// Result word channel: section byte and flags.
interface tspmt_out_if;
  logic                          valid;
  logic                          ready;
  logic [tspmt_pkg::BYTE_W-1:0]  out_byte;
  logic                          section_end;
  logic                          run_last;
  logic                          stray_error;

  modport source (output valid, out_byte, section_end, run_last, stray_error, input ready);
  modport sink   (input valid, out_byte, section_end, run_last, stray_error, output ready);
endinterface

// ===== sv/tspmt_cfg_if.sv =====
// Configuration write channel: register index and data.
interface tspmt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tspmt_pkg::CFG_IDX_W-1:0] index;
  logic [tspmt_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/tspmt_cfg.sv =====
// Configuration register bank of the PMT section generator.
module tspmt_cfg (
  input  logic              clk,
  input  logic              rst_n,
  tspmt_cfg_if.sink         cfg_ch,
  output tspmt_pkg::cfg_t   cfg
);
  import tspmt_pkg::*;

  cfg_t cfg_r;

  assign cfg_ch.ready = rst_n;
  assign cfg          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.es_type     <= '0;
      cfg_r.version     <= '0;
      cfg_r.cur_next    <= 1'b1;
      cfg_r.desc_len    <= '0;
      cfg_r.pid_low     <= '0;
    end else if (cfg_ch.valid) begin
      // unknown indices fall through and are dropped
      unique case (cfg_ch.index)
        REG_ES_TYPE:     cfg_r.es_type     <= cfg_ch.data[BYTE_W-1:0];
        REG_VERSION:     cfg_r.version     <= cfg_ch.data[VER_W-1:0];
        REG_CUR_NEXT:    cfg_r.cur_next    <= cfg_ch.data[0];
        REG_DESC_LEN:    cfg_r.desc_len    <= cfg_ch.data[DLEN_W-1:0];
        REG_PID_LOW:     cfg_r.pid_low     <= cfg_ch.data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/tspmt_engine.sv =====
// Job register, section state and byte selection with byte-wide CRC update.
module tspmt_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  tspmt_pkg::cfg_t   cfg,
  tspmt_in_if.sink          in_ch,
  input  logic              out_free,
  output tspmt_pkg::res_t   res
);
  import tspmt_pkg::*;

  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] x;
    x = c ^ {b, {(CRC_W-BYTE_W){1'b0}}};
    for (int i = 0; i < BYTE_W; i++) begin
      x = x[CRC_W-1] ? ((x << 1) ^ CRC_POLY) : (x << 1);
    end
    return x;
  endfunction

  function automatic logic [BYTE_W-1:0] hdr_byte(input logic [IDX_W-1:0] idx,
                                                 input cfg_t c);
    logic [11:0]       slen;
    logic [BYTE_W-1:0] b;
    slen = 12'(HDR_LEN) + {2'b00, c.desc_len};
    case (idx)
      5'd1:    b = 8'h02;
      5'd2:    b = 8'hB0 | {4'h0, slen[11:8]};
      5'd3:    b = slen[7:0];
      5'd5:    b = 8'h01;
      5'd6:    b = 8'hC0 | {2'b00, c.version, c.cur_next};
      5'd9:    b = 8'hE0;
      5'd10:   b = c.pid_low;
      5'd11:   b = 8'hF0;
      5'd13:   b = c.es_type;
      5'd14:   b = 8'hE0;
      5'd15:   b = c.pid_low;
      5'd16:   b = 8'hF0 | {6'h00, c.desc_len[9:8]};
      5'd17:   b = c.desc_len[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  logic              job_valid_r;
  action_t           job_act_r;
  logic [BYTE_W-1:0] job_byte_r;
  logic [IDX_W-1:0]  idx_r;
  logic [CRC_W-1:0]  crc_r;
  logic [DLEN_W-1:0] rem_r;
  logic              open_r;

  logic              is_hdr, is_desc, is_stray;
  logic              crc_phase, job_last, step, in_acc;
  logic [IDX_W-1:0]  k_full;
  logic [1:0]        crc_k;
  logic [BYTE_W-1:0] crc_out, hdr_out, byte_out;

  assign is_hdr   = (job_act_r == ACT_START);
  assign is_desc  = !is_hdr && open_r;
  assign is_stray = !is_hdr && !open_r;

  assign crc_phase = is_hdr ? (idx_r >= 5'(HDR_LEN)) : (is_desc && idx_r != '0);
  assign k_full    = is_hdr ? (idx_r - 5'(HDR_LEN)) : (idx_r - 5'd1);
  assign crc_k     = k_full[1:0];

  always_comb begin
    case (crc_k)
      2'd0:    crc_out = crc_r[31:24];
      2'd1:    crc_out = crc_r[23:16];
      2'd2:    crc_out = crc_r[15:8];
      default: crc_out = crc_r[7:0];
    endcase
  end

  assign hdr_out = hdr_byte(idx_r, cfg);

  always_comb begin
    if (is_stray)       byte_out = '0;
    else if (crc_phase) byte_out = crc_out;
    else if (is_hdr)    byte_out = hdr_out;
    else                byte_out = job_byte_r;
  end

  // an empty descriptor list puts the CRC straight after the header
  always_comb begin
    if (is_hdr)
      job_last = (idx_r == 5'(HDR_LEN - 1) && cfg.desc_len != '0) ||
                 (idx_r == 5'(HDR_LEN + CRC_LEN - 1));
    else if (is_desc)
      job_last = (idx_r == '0 && rem_r != 10'd1) || (idx_r == 5'(CRC_LEN));
    else
      job_last = 1'b1;
  end

  assign step        = job_valid_r && out_free;
  assign in_ch.ready = rst_n && (!job_valid_r || (step && job_last));
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign res.valid       = step;
  assign res.out_byte    = byte_out;
  assign res.section_end = crc_phase && (crc_k == 2'd3);
  assign res.run_last    = job_last;
  assign res.stray_error = is_stray;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      idx_r       <= '0;
      crc_r       <= CRC_INIT;
      rem_r       <= '0;
      open_r      <= 1'b0;
    end else begin
      if (in_acc) begin
        job_act_r  <= action_t'(in_ch.action);
        job_byte_r <= in_ch.descriptor_byte;
      end
      if (step && job_last) begin
        job_valid_r <= in_acc;
        idx_r       <= '0;
      end else if (step) begin
        idx_r <= idx_r + 5'd1;
      end else if (!job_valid_r) begin
        job_valid_r <= in_acc;
      end

      if (step) begin
        if (is_hdr && idx_r == '0) begin
          crc_r  <= CRC_INIT;
          open_r <= 1'b1;
          rem_r  <= cfg.desc_len;
        end else if (is_hdr && !crc_phase) begin
          crc_r <= crc_byte(crc_r, hdr_out);
        end else if (is_desc && idx_r == '0) begin
          crc_r <= crc_byte(crc_r, job_byte_r);
          rem_r <= rem_r - 10'd1;
        end
        // close the section on its last CRC byte
        if (res.section_end) begin
          open_r <= 1'b0;
          rem_r  <= '0;
        end
      end
    end
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid_r |-> idx_r <= 5'(HDR_LEN + CRC_LEN - 1))
    else $error("byte index past end of job");

  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.section_end |=> !open_r && rem_r == '0)
    else $error("section still open after final CRC byte");

  a_tail_count: assert property (@(posedge clk) disable iff (!rst_n)
    step && is_desc && crc_phase |-> rem_r == '0)
    else $error("CRC tail with descriptor bytes outstanding");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    step && !job_last |=> job_valid_r && idx_r == $past(idx_r) + 5'd1)
    else $error("job did not advance by one byte");

endmodule

// ===== sv/ts_pmt_section_generator.sv =====
// Top level of the PMT section generator: config bank, engine, output register.
//
//  channel | dir | payload                                       | accepted when
//  in_ch   | in  | action, descriptor_byte                       | valid & ready
//  out_ch  | out | out_byte, section_end, run_last, stray_error  | valid & ready
//  cfg_ch  | in  | index, data                                   | valid & ready
//
// One result word per cycle leaves the output register while out_ch.ready is high.
// A start word yields 18 words (22 with an empty descriptor list), a descriptor word
// 1 or 5, a stray word 1; in_ch.ready rises again as the engine forms the last of them,
// so the next input word is taken in that same cycle.
// Reset is synchronous: no section open, CRC preset, config at its defaults.
// A stall on out_ch holds the output register and freezes the engine.
module ts_pmt_section_generator (
  input  logic        clk,
  input  logic        rst_n,
  tspmt_in_if.sink    in_ch,
  tspmt_out_if.source out_ch,
  tspmt_cfg_if.sink   cfg_ch
);
  import tspmt_pkg::*;

  cfg_t              cfg;
  res_t              res;
  logic              out_free;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              section_end_r;
  logic              run_last_r;
  logic              stray_error_r;

  tspmt_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  tspmt_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_ch    (in_ch),
    .out_free (out_free),
    .res      (res)
  );

  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (res.valid) begin
        out_valid_r   <= 1'b1;
        out_byte_r    <= res.out_byte;
        section_end_r <= res.section_end;
        run_last_r    <= res.run_last;
        stray_error_r <= res.stray_error;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.section_end = section_end_r;
  assign out_ch.run_last    = run_last_r;
  assign out_ch.stray_error = stray_error_r;

endmodule

// ===== tb/pmt_section_checker.sv =====
// Checker for the PMT section generator: predicts each section word and compares.
`timescale 1ns / 1ps

module pmt_section_checker
  import tspmt_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  tspmt_in_if   in_ch,
  tspmt_out_if  out_ch,
  tspmt_cfg_if  cfg_ch,
  output int    fail_cnt,
  output int    pending,
  output int    words_in,
  output int    words_out,
  output int    sealed,
  output int    strays
);

  // section_length counts everything after its own field, the CRC included
  localparam logic [15:0] SEC_LEN_BASE = 16'd18;
  localparam int          MAX_REPORTS  = 10;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              sec_end;
    logic              last;
    logic              stray;
  } sec_word_t;

  cfg_t              shadow;
  logic [CRC_W-1:0]  sec_crc;
  logic [DLEN_W-1:0] sec_left;
  logic              sec_live;
  sec_word_t         want_q[$];
  int                reports;

  function automatic logic [CRC_W-1:0] crc_update(input logic [CRC_W-1:0] c,
                                                  input logic [BYTE_W-1:0] b);
    c = c ^ {b, 24'h0};
    for (int i = 0; i < 8; i++) begin
      c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // Work out every word one accepted input word causes and queue them in order.
  task automatic predict_word(input action_t act, input logic [BYTE_W-1:0] db);
    sec_word_t         burst[$];
    logic [15:0]       slen;
    logic [15:0]       esl;
    logic [BYTE_W-1:0] hdr [HDR_LEN];
    logic [BYTE_W-1:0] cb;
    if (act == ACT_START) begin
      slen     = 16'hB000 | (SEC_LEN_BASE + 16'(shadow.desc_len));
      esl      = 16'hF000 | 16'(shadow.desc_len);
      hdr[0]   = 8'h00;
      hdr[1]   = 8'h02;
      hdr[2]   = slen[15:8];
      hdr[3]   = slen[7:0];
      hdr[4]   = 8'h00;
      hdr[5]   = 8'h01;
      hdr[6]   = {2'b11, shadow.version, shadow.cur_next};
      hdr[7]   = 8'h00;
      hdr[8]   = 8'h00;
      hdr[9]   = 8'hE0;
      hdr[10]  = shadow.pid_low;
      hdr[11]  = 8'hF0;
      hdr[12]  = 8'h00;
      hdr[13]  = shadow.es_type;
      hdr[14]  = 8'hE0;
      hdr[15]  = shadow.pid_low;
      hdr[16]  = esl[15:8];
      hdr[17]  = esl[7:0];
      sec_crc  = CRC_INIT;
      for (int i = 0; i < HDR_LEN; i++) begin
        // pointer field stays outside the CRC
        if (i > 0) sec_crc = crc_update(sec_crc, hdr[i]);
        burst.push_back('{hdr[i], 1'b0, 1'b0, 1'b0});
      end
      sec_live = 1'b1;
      sec_left = shadow.desc_len;
    end else if (sec_live) begin
      sec_crc  = crc_update(sec_crc, db);
      burst.push_back('{db, 1'b0, 1'b0, 1'b0});
      sec_left = sec_left - DLEN_W'(1);
    end else begin
      burst.push_back('{8'h00, 1'b0, 1'b0, 1'b1});
    end
    if (sec_live && sec_left == '0) begin
      for (int i = 0; i < CRC_LEN; i++) begin
        cb = sec_crc[CRC_W-1-8*i -: 8];
        burst.push_back('{cb, i == CRC_LEN - 1, 1'b0, 1'b0});
      end
      sec_live = 1'b0;
    end
    burst[burst.size()-1].last = 1'b1;
    foreach (burst[i]) want_q.push_back(burst[i]);
  endtask

  always @(posedge clk) begin : watch
    sec_word_t w;
    if (!rst_n) begin
      shadow    = '{es_type: '0, version: '0, cur_next: 1'b1, desc_len: '0, pid_low: '0};
      sec_crc   = CRC_INIT;
      sec_left  = '0;
      sec_live  = 1'b0;
      want_q.delete();
      reports   = 0;
      fail_cnt  = 0;
      words_in  = 0;
      words_out = 0;
      sealed    = 0;
      strays    = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_reg_t'(cfg_ch.index))
          REG_ES_TYPE:     shadow.es_type     = cfg_ch.data[BYTE_W-1:0];
          REG_VERSION:     shadow.version     = cfg_ch.data[VER_W-1:0];
          REG_CUR_NEXT:    shadow.cur_next    = cfg_ch.data[0];
          REG_DESC_LEN:    shadow.desc_len    = cfg_ch.data[DLEN_W-1:0];
          REG_PID_LOW:     shadow.pid_low     = cfg_ch.data[BYTE_W-1:0];
          default: ;       // drop writes past the register list
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        words_in++;
        predict_word(action_t'(in_ch.action), in_ch.descriptor_byte);
      end
      if (out_ch.valid && out_ch.ready) begin
        words_out++;
        if (want_q.size() == 0) begin
          fail_cnt++;
          if (reports < MAX_REPORTS)
            $display("[%0t] unexpected word: byte %02h end %b last %b stray %b", $realtime,
                     out_ch.out_byte, out_ch.section_end, out_ch.run_last,
                     out_ch.stray_error);
          reports++;
        end else begin
          w = want_q.pop_front();
          if (out_ch.out_byte !== w.data || out_ch.section_end !== w.sec_end ||
              out_ch.run_last !== w.last || out_ch.stray_error !== w.stray) begin
            fail_cnt++;
            if (reports < MAX_REPORTS)
              $display({"[%0t] word %0d: expected byte %02h end %b last %b stray %b,",
                        " got %02h %b %b %b"},
                       $realtime, words_out, w.data, w.sec_end, w.last, w.stray,
                       out_ch.out_byte, out_ch.section_end, out_ch.run_last,
                       out_ch.stray_error);
            reports++;
          end
          if (w.sec_end) sealed++;
          if (w.stray) strays++;
        end
      end
    end
    pending = want_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the PMT section generator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import tspmt_pkg::*;

  localparam int ITEMS    = 310;
  localparam int LIMIT    = 400_000;
  localparam int IDLE_PCT = 16;
  localparam int TAIL     = 32;

  typedef struct {
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DAT_W-1:0] val;
  } reg_write_t;

  logic       clk;
  logic       rst_n;
  logic       calm;
  int         sent;
  int         cycles;
  int         fail_cnt, pending, words_in, words_out, sealed, strays;
  reg_write_t reg_q[$];

  tspmt_in_if  in_ch();
  tspmt_out_if out_ch();
  tspmt_cfg_if cfg_ch();

  ts_pmt_section_generator DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  pmt_section_checker u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_ch    (cfg_ch),
    .fail_cnt  (fail_cnt),
    .pending   (pending),
    .words_in  (words_in),
    .words_out (words_out),
    .sealed    (sealed),
    .strays    (strays)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_top: errors");
    $finish;
  end

  // Hold the word until it is taken; valid drops only for a random idle gap or in settle.
  task automatic push_word(input action_t act, input logic [BYTE_W-1:0] db);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.action          <= act;
    in_ch.descriptor_byte <= db;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  task automatic push_random_desc(input int n);
    repeat (n) push_word(ACT_DESC, BYTE_W'($urandom_range(0, 255)));
  endtask

  // Stop sending and wait until every predicted word has come out.
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    reg_q.push_back('{idx, val});
  endtask

  task automatic write_regs();
    foreach (reg_q[i]) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= reg_q[i].idx;
      cfg_ch.data  <= reg_q[i].val;
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
    reg_q.delete();
  endtask

  // Mostly in-range values; now and then full-width data that the block must mask.
  task automatic random_regs(input logic [DLEN_W-1:0] dlen);
    logic wide;
    wide = ($urandom_range(0, 3) == 0);
    add_reg(REG_ES_TYPE, wide ? CFG_DAT_W'($urandom) : CFG_DAT_W'($urandom_range(0, 255)));
    add_reg(REG_VERSION, wide ? CFG_DAT_W'($urandom) : CFG_DAT_W'($urandom_range(0, 31)));
    add_reg(REG_CUR_NEXT, wide ? CFG_DAT_W'($urandom) : CFG_DAT_W'($urandom_range(0, 1)));
    add_reg(REG_PID_LOW, wide ? CFG_DAT_W'($urandom) : CFG_DAT_W'($urandom_range(0, 255)));
    if (wide)
      add_reg(CFG_IDX_W'($urandom_range(int'(REG_PID_LOW) + 1, (1 << CFG_IDX_W) - 1)),
              CFG_DAT_W'($urandom));
    add_reg(REG_DESC_LEN, dlen);
  endtask

  initial begin : stimulus
    int               phase;
    int               budget;
    int               r;
    int               cut;
    logic [DLEN_W-1:0] plen;

    rst_n                 <= 1'b0;
    calm                  <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.action          <= ACT_START;
    in_ch.descriptor_byte <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= '0;
    cfg_ch.data           <= '0;
    sent = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: empty descriptor list, then bytes with no section open
    push_word(ACT_START, 8'hC3);
    push_word(ACT_DESC, 8'hFF);
    push_word(ACT_DESC, 8'h00);
    settle();

    add_reg(REG_ES_TYPE, 10'h0FF);
    add_reg(REG_VERSION, 10'd31);
    add_reg(REG_CUR_NEXT, 10'd0);
    add_reg(REG_DESC_LEN, 10'd3);
    add_reg(REG_PID_LOW, 10'h0FF);
    write_regs();
    push_word(ACT_START, 8'h00);
    push_word(ACT_DESC, 8'h00);
    push_word(ACT_DESC, 8'hFF);
    push_word(ACT_DESC, 8'hA5);
    // abandon an open section with a fresh start
    push_word(ACT_START, 8'h00);
    push_word(ACT_DESC, 8'h5A);
    push_word(ACT_START, 8'hFF);
    push_word(ACT_DESC, 8'hC3);
    push_word(ACT_DESC, 8'h3C);
    push_word(ACT_DESC, 8'h81);
    settle();

    // full-width writes: only each register's width is kept, spare indexes dropped
    add_reg(REG_ES_TYPE, 10'h3FF);
    add_reg(REG_VERSION, 10'h3E0);
    add_reg(REG_CUR_NEXT, 10'h3FF);
    add_reg(REG_PID_LOW, 10'h300);
    add_reg(REG_DESC_LEN, 10'h3FF);
    for (int i = int'(REG_PID_LOW) + 1; i < (1 << CFG_IDX_W); i++)
      add_reg(CFG_IDX_W'(i), 10'h3FF);
    write_regs();
    push_word(ACT_START, 8'h00);
    push_word(ACT_DESC, 8'h12);
    push_word(ACT_START, 8'h00);
    settle();
    add_reg(REG_DESC_LEN, 10'd1);
    write_regs();
    push_word(ACT_START, 8'h00);
    push_word(ACT_DESC, 8'h7E);

    phase = 0;
    while (sent < ITEMS) begin
      settle();
      calm <= (phase == 2);
      r = $urandom_range(0, 99);
      if (phase == 1)  plen = 10'd1003;
      else if (r < 10) plen = '0;
      else if (r < 20) plen = 10'd1;
      else if (r < 88) plen = DLEN_W'($urandom_range(2, 12));
      else if (r < 95) plen = DLEN_W'($urandom_range(30, 40));
      else             plen = 10'd1023;
      random_regs(plen);
      write_regs();
      budget = $urandom_range(25, 50);
      if (plen > 100) begin
        // long lists: check the header and abandon after a few bytes
        repeat (2) begin
          push_word(ACT_START, BYTE_W'($urandom));
          push_random_desc($urandom_range(0, 5));
        end
      end else begin
        while (budget > 0) begin
          r = $urandom_range(0, 99);
          if (r < 75) begin
            push_word(ACT_START, BYTE_W'($urandom));
            push_random_desc(plen);
            budget -= plen + 1;
          end else if (r < 87) begin
            cut = (plen > 0) ? $urandom_range(0, plen - 1) : 0;
            push_word(ACT_START, BYTE_W'($urandom));
            push_random_desc(cut);
            budget -= cut + 1;
          end else begin
            cut = $urandom_range(1, 3);
            push_random_desc(cut);
            budget -= cut;
          end
        end
      end
      phase++;
    end

    settle();
    repeat (TAIL) @(posedge clk);
    $display("summary: %0d input words, %0d result words, %0d sections sealed, %0d stray bytes",
             words_in, words_out, sealed, strays);
    $display("summary: %0d random settings, descriptor lengths 0 to 1023, one phase without stalls",
             phase);
    if (fail_cnt == 0 && pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/tspmt_pkg.sv
sv/tspmt_in_if.sv
sv/tspmt_out_if.sv
sv/tspmt_cfg_if.sv
sv/tspmt_cfg.sv
sv/tspmt_engine.sv
sv/ts_pmt_section_generator.sv
tb/pmt_section_checker.sv
tb/tb_top.sv
